FILE: hdl/tick_count_to_100ns_converter_macros.svh
// Assertion helpers for the top-level RTL. Expect clk_i and rst_ni in scope.
`ifndef TICK_COUNT_TO_100NS_CONVERTER_MACROS_SVH
`define TICK_COUNT_TO_100NS_CONVERTER_MACROS_SVH

// Clocked property, off during reset.
`define TC100_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define TC100_ASSERT_IMPL(lbl, ante, cons, msg) \
  `TC100_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: hdl/tc100_pkg.sv
package tc100_pkg;

  // Number of 100 ns units in one second.
  localparam logic [23:0] UnitsPerSec = 24'd10000000;
  // Bits of UnitsPerSec walked by the fraction divider.
  localparam int unsigned FracSteps = 24;
  // Quotient bits of the integer divider.
  localparam int unsigned DivSteps = 63;
  // Largest quotient whose product with UnitsPerSec fits 64 bits.
  localparam logic [62:0] WholeMax = 63'd1844674407370;

  // Integer divider result.
  typedef struct packed {
    logic [62:0] quo;
    logic [62:0] rem;
    logic        bad;
  } div_res_t;

  // Whole part and fraction operands.
  typedef struct packed {
    logic [63:0] whole;
    logic [62:0] rem;
    logic [62:0] gap;
    logic        bad;
  } mul_res_t;

  // Fraction divider result.
  typedef struct packed {
    logic [63:0] whole;
    logic [23:0] frac;
    logic [62:0] acc;
    logic        bad;
  } frac_res_t;

endpackage

FILE: hdl/tc100_div.sv
module tc100_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [62:0]         freq_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         tick_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tc100_pkg::div_res_t out_o
);
  import tc100_pkg::*;

  typedef struct packed {
    logic [62:0] tk;
    logic [62:0] rm;
    logic [62:0] qt;
    logic        bad;
  } div_stage_t;

  div_stage_t              st_q [DivSteps];
  logic [DivSteps-1:0]     vld_q;
  logic [DivSteps:0]       rdy;
  logic [DivSteps-1:0]     prv;

  // Per-stage ready: a stage loads when empty or when its word moves on.
  always_comb begin
    rdy[DivSteps] = out_ready_i;
    for (int s = DivSteps - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign prv = {vld_q[DivSteps-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (rdy[DivSteps-1:0] & prv) | (~rdy[DivSteps-1:0] & vld_q);
    end
  end

  // One restoring quotient bit per stage, MSB first.
  for (genvar s = 0; s < DivSteps; s++) begin : g_st
    div_stage_t  src;
    div_stage_t  nxt;
    logic [63:0] rsh;
    logic        ge;

    if (s == 0) begin : g_head
      assign src = {tick_i[62:0], 63'd0, 63'd0, tick_i[63] | (freq_i == '0)};
    end else begin : g_body
      assign src = st_q[s-1];
    end

    always_comb begin
      rsh = {src.rm, src.tk[DivSteps-1-s]};
      ge  = rsh >= {1'b0, freq_i};
      nxt = src;
      nxt.rm = ge ? 63'(rsh - {1'b0, freq_i}) : rsh[62:0];
      nxt.qt[DivSteps-1-s] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && prv[s]) begin
        st_q[s] <= nxt;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[DivSteps-1];
  assign out_o       = '{quo: st_q[DivSteps-1].qt, rem: st_q[DivSteps-1].rm,
                         bad: st_q[DivSteps-1].bad};

endmodule

FILE: hdl/tc100_mul.sv
module tc100_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [62:0]         freq_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tc100_pkg::div_res_t in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tc100_pkg::mul_res_t out_o
);
  import tc100_pkg::*;

  typedef struct packed {
    logic [44:0] pl;
    logic [43:0] ph;
    logic [62:0] rem;
    logic [62:0] gap;
    logic        bad;
  } mul_stage_t;

  mul_stage_t  m1_q;
  mul_stage_t  m1_d;
  mul_res_t    m2_q;
  mul_res_t    m2_d;
  logic        v1_q;
  logic        v2_q;
  logic        rdy1;
  logic        rdy2;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;

  // Stage 1: overflow check and two partial products of quo * 10^7.
  always_comb begin
    m1_d.pl  = {24'd0, in_i.quo[20:0]} * {21'd0, UnitsPerSec};
    m1_d.ph  = {24'd0, in_i.quo[40:21]} * {20'd0, UnitsPerSec};
    m1_d.rem = in_i.rem;
    m1_d.gap = freq_i - in_i.rem;
    m1_d.bad = in_i.bad || (in_i.quo > WholeMax);
  end

  // Stage 2: combine partial products.
  always_comb begin
    m2_d.whole = {19'd0, m1_q.pl} + {m1_q.ph[42:0], 21'd0};
    m2_d.rem   = m1_q.rem;
    m2_d.gap   = m1_q.gap;
    m2_d.bad   = m1_q.bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) m1_q <= m1_d;
    if (rdy2 && v1_q) m2_q <= m2_d;
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v2_q;
  assign out_o       = m2_q;

endmodule

FILE: hdl/tc100_frac.sv
module tc100_frac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [62:0]          freq_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tc100_pkg::mul_res_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tc100_pkg::frac_res_t out_o
);
  import tc100_pkg::*;

  typedef struct packed {
    logic [63:0] whole;
    logic [62:0] rem;
    logic [62:0] gap;
    logic [62:0] acc;
    logic [23:0] quo;
    logic        bad;
  } frac_stage_t;

  frac_stage_t          st_q [FracSteps];
  logic [FracSteps-1:0] vld_q;
  logic [FracSteps:0]   rdy;
  logic [FracSteps-1:0] prv;

  always_comb begin
    rdy[FracSteps] = out_ready_i;
    for (int s = FracSteps - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign prv = {vld_q[FracSteps-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (rdy[FracSteps-1:0] & prv) | (~rdy[FracSteps-1:0] & vld_q);
    end
  end

  // One bit of 10^7 per stage, MSB first: double, reduce, then add rem
  // modulo f where the bit is set.
  for (genvar s = 0; s < FracSteps; s++) begin : g_st
    frac_stage_t src;
    frac_stage_t nxt;
    logic [63:0] a2;
    logic [62:0] a1;
    logic        c1;
    logic        c2;

    if (s == 0) begin : g_head
      assign src = {in_i.whole, in_i.rem, in_i.gap, 63'd0, 24'd0, in_i.bad};
    end else begin : g_body
      assign src = st_q[s-1];
    end

    always_comb begin
      a2  = {src.acc, 1'b0};
      c1  = a2 >= {1'b0, freq_i};
      a1  = c1 ? 63'(a2 - {1'b0, freq_i}) : a2[62:0];
      c2  = 1'b0;
      nxt = src;
      nxt.acc = a1;
      if (UnitsPerSec[FracSteps-1-s]) begin
        c2 = a1 >= src.gap;
        nxt.acc = c2 ? (a1 - src.gap) : (a1 + src.rem);
      end
      nxt.quo = {src.quo[22:0], 1'b0} + {23'd0, c1} + {23'd0, c2};
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && prv[s]) begin
        st_q[s] <= nxt;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[FracSteps-1];
  assign out_o       = '{whole: st_q[FracSteps-1].whole, frac: st_q[FracSteps-1].quo,
                         acc: st_q[FracSteps-1].acc, bad: st_q[FracSteps-1].bad};

endmodule

FILE: hdl/tick_count_to_100ns_converter.sv
// Channel      | Direction | Handshake              | Word
// in           | input     | in_valid_i/in_ready_o  | tick_count_i[63:0] signed
// out          | output    | out_valid_o/out_ready_i| time_100ns_o[62:0], ok_o
// config       | input     | ticks_per_second_we_i  | ticks_per_second_i[62:0]
//
// The pipeline has 63 divider stages, 2 multiply stages, 24 fraction
// stages and the output register. One word enters per cycle when no stall.
// Reset clears all valid bits and loads a frequency of 10000000.
// Each stage holds its word under backpressure and fills bubbles upstream.
module tick_count_to_100ns_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ticks_per_second_we_i,
  input  logic [62:0] ticks_per_second_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] tick_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [62:0] time_100ns_o,
  output logic        ok_o
);
  import tc100_pkg::*;

  `include "tick_count_to_100ns_converter_macros.svh"

  logic [62:0] freq_q;
  div_res_t    div_res;
  mul_res_t    mul_res;
  frac_res_t   frac_res;
  logic        div_valid;
  logic        div_ready;
  logic        mul_valid;
  logic        mul_ready;
  logic        frac_valid;
  logic        frac_ready;
  logic [64:0] sum;
  logic        out_valid_q;
  logic [62:0] time_q;
  logic        ok_q;

  // Frequency register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= {39'd0, UnitsPerSec};
    end else if (ticks_per_second_we_i) begin
      freq_q <= ticks_per_second_i;
    end
  end

  tc100_div u_div (
    .clk_i, .rst_ni,
    .freq_i      (freq_q),
    .in_valid_i,
    .in_ready_o,
    .tick_i      (tick_count_i),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_res)
  );

  tc100_mul u_mul (
    .clk_i, .rst_ni,
    .freq_i      (freq_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_i        (div_res),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .out_o       (mul_res)
  );

  tc100_frac u_frac (
    .clk_i, .rst_ni,
    .freq_i      (freq_q),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .in_i        (mul_res),
    .out_valid_o (frac_valid),
    .out_ready_i (frac_ready),
    .out_o       (frac_res)
  );

  // Final sum, range check and output register.
  assign sum        = {1'b0, frac_res.whole} + {41'd0, frac_res.frac};
  assign frac_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frac_ready) begin
      out_valid_q <= frac_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frac_ready && frac_valid) begin
      ok_q   <= !(frac_res.bad || sum[64] || sum[63]);
      time_q <= (frac_res.bad || sum[64] || sum[63]) ? 63'd0 : sum[62:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign time_100ns_o = time_q;
  assign ok_o         = ok_q;

  // Checks
  `TC100_ASSERT_IMPL(a_err_zero, out_valid_o && !ok_o, time_100ns_o == '0, "error word with time")
  `TC100_ASSERT_IMPL(a_div_rem, div_valid && !div_res.bad, div_res.rem < freq_q, "rem >= freq")
  `TC100_ASSERT_IMPL(a_frac_acc, frac_valid && !frac_res.bad, frac_res.acc < freq_q, "acc >= freq")
  `TC100_ASSERT_IMPL(a_frac_rng, frac_valid && !frac_res.bad, frac_res.frac < UnitsPerSec, "frac range")

endmodule
